@@ sv/opke_pkg.sv @@
// Package for the order-preserving key encoder.
// Holds column kind codes, status codes and the encoded-item record.
// No dependencies.
package opke_pkg;

    localparam logic [2:0] KIND_BOOL    = 3'd0;
    localparam logic [2:0] KIND_INT32   = 3'd1;
    localparam logic [2:0] KIND_INT64   = 3'd2;
    localparam logic [2:0] KIND_UINT64  = 3'd3;
    localparam logic [2:0] KIND_FLOAT32 = 3'd4;
    localparam logic [2:0] KIND_FLOAT64 = 3'd5;
    localparam logic [2:0] KIND_VARLEN  = 3'd6;
    localparam logic [2:0] KIND_PAYLOAD = 3'd7;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NULL        = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
    localparam logic [1:0] STATUS_STRAY_BYTE  = 2'd3;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    // One encoded column, left-aligned so the first byte sits in bits 63:56.
    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  last_idx;   // number of bytes minus one
        logic        eok;
        logic [1:0]  status;
    } enc_item_t;

endpackage

@@ sv/order_preserving_key_encoder_core.sv @@
// Order-preserving key encoder, top level: one key column per request in, its
// byte-comparable encoding out, most significant byte first, one byte per result.
// A request is registered into an encode register, and the serializer then shows it
// as many result bytes as the column has: one for bool, payload bytes and errors,
// four for int32, float32 and varlen headers, eight for the 64-bit kinds. The encode
// register accepts a new request while the serializer still shows the previous one,
// so the sustained rate is one result byte per cycle while m_ready stays high, set by
// the byte-wide output serializer. Depends on opke_pkg, opke_encode and opke_serializer.
module order_preserving_key_encoder_core import opke_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_column_kind,
    input  logic [63:0] s_field_value,
    input  logic        s_is_null,
    input  logic        s_last_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_key_byte,
    output logic        m_last_of_item,
    output logic        m_end_of_key,
    output logic [1:0]  m_status
);

    logic      enc_valid;
    enc_item_t enc_item;
    logic      enc_take;

    opke_encode u_encode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_column_kind (s_column_kind),
        .s_field_value (s_field_value),
        .s_is_null     (s_is_null),
        .s_last_column (s_last_column),
        .enc_valid     (enc_valid),
        .enc_item      (enc_item),
        .enc_take      (enc_take)
    );

    opke_serializer u_serializer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .enc_valid      (enc_valid),
        .enc_item       (enc_item),
        .enc_take       (enc_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_byte     (m_key_byte),
        .m_last_of_item (m_last_of_item),
        .m_end_of_key   (m_end_of_key),
        .m_status       (m_status)
    );

    // An error result is always a single zero byte.
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |-> (m_last_of_item && m_key_byte == 8'd0))
        else $error("error result is not a single zero byte");

    a_eok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_key) |-> m_last_of_item)
        else $error("end of key flagged before the last byte of an item");

    // A waiting encoded item is held until the serializer takes it.
    a_enc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (enc_valid && !enc_take) |=> (enc_valid && $stable(enc_item)))
        else $error("encoded item lost or input accepted over it");

    // The serializer only loads when its current word is done.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (enc_take && m_valid) |-> (m_ready && m_last_of_item))
        else $error("serializer reloaded before finishing a word");

endmodule

@@ sv/opke_encode.sv @@
// Input stage of the key encoder: encodes one request into a left-aligned word.
// Tracks the pending varlen payload count. Depends on opke_pkg.
module opke_encode import opke_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_column_kind,
    input  logic [63:0] s_field_value,
    input  logic        s_is_null,
    input  logic        s_last_column,
    output logic        enc_valid,
    output enc_item_t   enc_item,
    input  logic        enc_take
);

    logic        enc_valid_reg;
    enc_item_t   enc_reg;
    enc_item_t   item_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] w32;
    logic        accept;

    assign s_ready   = !enc_valid_reg || enc_take;
    assign accept    = s_valid && s_ready;
    assign enc_valid = enc_valid_reg;
    assign enc_item  = enc_reg;
    assign w32       = s_field_value[31:0];

    always_comb begin
        item_next          = '0;
        item_next.eok      = s_last_column;
        item_next.status   = STATUS_OK;
        item_next.last_idx = 3'd0;
        rem_next           = 32'd0;
        if (s_column_kind == KIND_PAYLOAD) begin
            if (rem_reg == 32'd0) begin
                item_next.status = STATUS_STRAY_BYTE;
            end else begin
                rem_next       = rem_reg - 32'd1;
                item_next.word = {s_field_value[7:0], 56'd0};
            end
        end else if (s_is_null) begin
            item_next.status = STATUS_NULL;
        end else begin
            case (s_column_kind)
                KIND_BOOL: begin
                    item_next.word = {7'd0, (s_field_value != 64'd0), 56'd0};
                end
                KIND_INT32: begin
                    item_next.word     = {w32 ^ SIGN32, 32'd0};
                    item_next.last_idx = 3'd3;
                end
                KIND_INT64: begin
                    item_next.word     = s_field_value ^ SIGN64;
                    item_next.last_idx = 3'd7;
                end
                KIND_UINT64: begin
                    item_next.word     = s_field_value;
                    item_next.last_idx = 3'd7;
                end
                KIND_FLOAT32: begin
                    // Negative floats invert fully; positive ones just gain the sign bit.
                    item_next.word     = {(w32[31] ? ~w32 : (w32 | SIGN32)), 32'd0};
                    item_next.last_idx = 3'd3;
                end
                KIND_FLOAT64: begin
                    item_next.word     = s_field_value[63] ? ~s_field_value
                                                           : (s_field_value | SIGN64);
                    item_next.last_idx = 3'd7;
                end
                KIND_VARLEN: begin
                    if (s_field_value[63:32] != 32'd0) begin
                        item_next.status = STATUS_UNSUPPORTED;
                    end else begin
                        item_next.word     = {w32, 32'd0};
                        item_next.last_idx = 3'd3;
                        rem_next           = w32;
                    end
                end
                default: begin
                    item_next.status = STATUS_UNSUPPORTED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_valid_reg <= 1'b0;
            rem_reg       <= 32'd0;
        end else begin
            if (accept) begin
                enc_valid_reg <= 1'b1;
                rem_reg       <= rem_next;
            end else if (enc_take) begin
                enc_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            enc_reg <= item_next;
        end
    end

endmodule

@@ sv/opke_serializer.sv @@
// Output stage of the key encoder: shifts an encoded word out one byte per result.
// Depends on opke_pkg.
module opke_serializer import opke_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        enc_valid,
    input  enc_item_t   enc_item,
    output logic        enc_take,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_key_byte,
    output logic        m_last_of_item,
    output logic        m_end_of_key,
    output logic [1:0]  m_status
);

    logic        m_valid_reg;
    logic [63:0] word_reg;
    logic [2:0]  cnt_reg;
    logic        eok_reg;
    logic [1:0]  status_reg;
    logic        last_beat;
    logic        room;

    assign last_beat = (cnt_reg == 3'd0);
    // Free now, or the final byte of the current word leaves this cycle.
    assign room      = !m_valid_reg || (m_ready && last_beat);
    assign enc_take  = enc_valid && room;

    assign m_valid        = m_valid_reg;
    assign m_key_byte     = word_reg[63:56];
    assign m_last_of_item = last_beat;
    assign m_end_of_key   = last_beat && eok_reg;
    assign m_status       = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= 3'd0;
        end else begin
            if (enc_take) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= enc_item.last_idx;
            end else if (m_valid_reg && m_ready) begin
                if (last_beat) begin
                    m_valid_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enc_take) begin
            word_reg   <= enc_item.word;
            eok_reg    <= enc_item.eok;
            status_reg <= enc_item.status;
        end else if (m_valid_reg && m_ready && !last_beat) begin
            word_reg <= {word_reg[55:0], 8'd0};
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for order_preserving_key_encoder_core: predicts the encoded
// key bytes of every accepted column request and compares them with the output stream.
// Depends on opke_pkg and the encoder RTL.
module tb_top import opke_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_of_item;
        logic       end_of_key;
        logic [1:0] status;
    } key_result_t;

    // Holds the byte-comparable encoding expected for each accepted request.
    class key_byte_scoreboard;
        key_result_t expected_bytes[$];
        logic [31:0] payload_left;
        int unsigned failures;

        function new();
            payload_left = '0;
            failures = 0;
        endfunction

        function void push_bytes(logic [63:0] word, int unsigned nbytes, logic last_col);
            key_result_t r;
            for (int i = nbytes - 1; i >= 0; i--) begin
                r.key_byte = word[i*8 +: 8];
                r.last_of_item = (i == 0);
                r.end_of_key = (i == 0) ? last_col : 1'b0;
                r.status = STATUS_OK;
                expected_bytes = {expected_bytes, r};
            end
        endfunction

        // Any error produces one zero byte carrying the status and clears the payload count.
        function void push_error(logic last_col, logic [1:0] code);
            key_result_t r;
            payload_left = '0;
            r.key_byte = 8'h00;
            r.last_of_item = 1'b1;
            r.end_of_key = last_col;
            r.status = code;
            expected_bytes = {expected_bytes, r};
        endfunction

        function void note_request(logic [2:0] kind, logic [63:0] value, logic is_null,
                                   logic last_col);
            logic [31:0] w32;
            logic [63:0] word;
            int unsigned nbytes;
            w32 = value[31:0];
            if (kind == KIND_PAYLOAD) begin
                if (payload_left == 0) begin
                    push_error(last_col, STATUS_STRAY_BYTE);
                end else begin
                    payload_left--;
                    push_bytes({56'b0, value[7:0]}, 1, last_col);
                end
                return;
            end
            // A column item always ends any payload still outstanding.
            payload_left = '0;
            if (is_null) begin
                push_error(last_col, STATUS_NULL);
                return;
            end
            word = '0;
            nbytes = 8;
            case (kind)
                KIND_BOOL: begin
                    word = {63'b0, value != 64'b0};
                    nbytes = 1;
                end
                KIND_INT32: begin
                    word = {32'b0, w32 ^ SIGN32};
                    nbytes = 4;
                end
                KIND_INT64: word = value ^ SIGN64;
                KIND_UINT64: word = value;
                KIND_FLOAT32: begin
                    word = {32'b0, w32[31] ? ~w32 : (w32 | SIGN32)};
                    nbytes = 4;
                end
                KIND_FLOAT64: word = value[63] ? ~value : (value | SIGN64);
                default: begin
                    if (value[63:32] != 32'b0) begin
                        push_error(last_col, STATUS_UNSUPPORTED);
                        return;
                    end
                    word = value;
                    nbytes = 4;
                    payload_left = w32;
                end
            endcase
            push_bytes(word, nbytes, last_col);
        endfunction

        function void check_result(key_result_t got);
            key_result_t exp;
            if (expected_bytes.size() == 0) begin
                $error("unexpected key byte %0h, nothing outstanding", got.key_byte);
                failures++;
                return;
            end
            exp = expected_bytes.pop_front();
            if (got.key_byte !== exp.key_byte) begin
                $error("key_byte mismatch: expected %0h, got %0h", exp.key_byte, got.key_byte);
                failures++;
            end
            if (got.last_of_item !== exp.last_of_item) begin
                $error("last_of_item mismatch: expected %0b, got %0b",
                       exp.last_of_item, got.last_of_item);
                failures++;
            end
            if (got.end_of_key !== exp.end_of_key) begin
                $error("end_of_key mismatch: expected %0b, got %0b",
                       exp.end_of_key, got.end_of_key);
                failures++;
            end
            if (got.status !== exp.status) begin
                $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_column_kind = KIND_BOOL;
    logic [63:0] s_field_value = '0;
    logic        s_is_null = 1'b0;
    logic        s_last_column = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_key_byte;
    logic        m_last_of_item;
    logic        m_end_of_key;
    logic [1:0]  m_status;

    int unsigned send_idle_pct = 16;
    int unsigned recv_stall_pct = 49;
    int unsigned requests_sent = 0;

    key_byte_scoreboard sb = new();

    order_preserving_key_encoder_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_column_kind  (s_column_kind),
        .s_field_value  (s_field_value),
        .s_is_null      (s_is_null),
        .s_last_column  (s_last_column),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_byte     (m_key_byte),
        .m_last_of_item (m_last_of_item),
        .m_end_of_key   (m_end_of_key),
        .m_status       (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Output side: check every accepted byte, then pick the next ready level.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            sb.check_result({m_key_byte, m_last_of_item, m_end_of_key, m_status});
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid is lowered only during an idle cycle, so back-to-back requests keep it high.
    task automatic send_request(logic [2:0] kind, logic [63:0] value, logic is_null,
                                logic last_col);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_column_kind <= kind;
        s_field_value <= value;
        s_is_null <= is_null;
        s_last_column <= last_col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(kind, value, is_null, last_col);
        requests_sent++;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return SIGN64;
            3: return ~SIGN64;
            4: return {32'b0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One well-formed key: a few columns, varlen headers followed by their payload.
    task automatic send_key();
        int unsigned ncols;
        int unsigned plen;
        int unsigned c;
        int unsigned b;
        logic [2:0] kind;
        logic null_col;
        logic last_col;
        ncols = $urandom_range(4, 1);
        for (c = 0; c < ncols; c++) begin
            kind = 3'($urandom_range(KIND_VARLEN));
            null_col = ($urandom_range(19) == 0);
            last_col = (c == ncols - 1);
            if (kind == KIND_VARLEN && !null_col) begin
                plen = $urandom_range(5);
                send_request(KIND_VARLEN, 64'(plen), 1'b0, last_col && plen == 0);
                for (b = 0; b < plen; b++) begin
                    send_request(KIND_PAYLOAD, {$urandom, $urandom}, 1'($urandom_range(1)),
                                 last_col && b == plen - 1);
                end
            end else begin
                send_request(kind, rand_value(), null_col, last_col);
            end
        end
    endtask

    task automatic send_random(int unsigned count);
        int unsigned target;
        target = requests_sent + count;
        while (requests_sent < target) begin
            if ($urandom_range(99) < 85) begin
                send_key();
            end else begin
                send_request(3'($urandom_range(7)), rand_value(),
                             ($urandom_range(3) == 0), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every kind, and the error and payload corner cases.
        send_request(KIND_BOOL, 64'h0, 1'b0, 1'b0);
        send_request(KIND_BOOL, SIGN64, 1'b0, 1'b1);
        send_request(KIND_INT32, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        send_request(KIND_INT32, 64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0);
        send_request(KIND_INT64, SIGN64, 1'b0, 1'b0);
        send_request(KIND_INT64, ~SIGN64, 1'b0, 1'b0);
        send_request(KIND_UINT64, '0, 1'b0, 1'b0);
        send_request(KIND_UINT64, '1, 1'b0, 1'b1);
        send_request(KIND_FLOAT32, 64'h0000_0000_BF80_0000, 1'b0, 1'b0);
        send_request(KIND_FLOAT32, 64'h1234_5678_3F80_0000, 1'b0, 1'b0);
        send_request(KIND_FLOAT64, 64'hBFF0_0000_0000_0000, 1'b0, 1'b0);
        send_request(KIND_FLOAT64, 64'h0, 1'b0, 1'b0);
        send_request(KIND_INT64, 64'h55, 1'b1, 1'b1);
        send_request(KIND_VARLEN, 64'd3, 1'b0, 1'b0);
        send_request(KIND_PAYLOAD, 64'hFFFF_FFFF_FFFF_FFAB, 1'b0, 1'b0);
        send_request(KIND_PAYLOAD, 64'h00, 1'b1, 1'b0);
        send_request(KIND_PAYLOAD, 64'hFF, 1'b0, 1'b1);
        send_request(KIND_PAYLOAD, 64'h42, 1'b0, 1'b0);
        send_request(KIND_VARLEN, 64'h1_0000_0000, 1'b0, 1'b0);
        send_request(KIND_VARLEN, 64'hFFFF_FFFF, 1'b0, 1'b0);
        send_request(KIND_PAYLOAD, 64'h7E, 1'b0, 1'b0);
        send_request(KIND_UINT64, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        send_request(KIND_PAYLOAD, 64'h11, 1'b0, 1'b1);
        send_request(KIND_VARLEN, 64'd2, 1'b1, 1'b1);

        send_random(70);
        send_idle_pct = 49;
        recv_stall_pct = 16;
        send_random(65);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(65);
        s_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/opke_pkg.sv
sv/opke_encode.sv
sv/opke_serializer.sv
sv/order_preserving_key_encoder_core.sv
sim/tb_top.sv
